// ===== design/lasb_pkg.sv =====
// Shared types and constants of the lidar angular scan binner.
`default_nettype none

package lasb_pkg;

  localparam int unsigned FullTurn = 23040;
  localparam int unsigned PaddrW   = 4;

  localparam logic [15:0] MinDistRst  = 16'd12;
  localparam logic [19:0] DebounceRst = 20'd30000;
  localparam logic [14:0] AngleOfsRst = 15'd5760;

  typedef enum logic [1:0] {
    REQ_MEAS  = 2'd0,
    REQ_PULSE = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic {
    KIND_SCAN_DONE = 1'b0,
    KIND_BIN_READ  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_MIN_DIST  = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_ANGLE_OFS = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] distance_cm;
    logic [14:0] angle_pos;
    logic [31:0] timestamp_us;
    logic [6:0]  bin_index;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic        finished_bank;
    logic [15:0] bin_distance;
    logic        bin_valid;
  } out_word_t;

  typedef struct packed {
    logic [15:0] min_distance;
    logic [19:0] debounce_us;
    logic [14:0] angle_offset;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/lidar_angular_scan_binner.sv =====
// Top level of the lidar angular scan binner: pipeline, bin store and banks.
// A taken input word passes the stage A, B and C registers and then the output register.
// Throughput: one word per cycle while the output drains; output stall holds the pipe.
// The bin store is read one stage before it is written; a same-slot write forwards.
// Reset clears the valid and written marks of both banks, selects bank zero for writing,
// zeroes the last pulse time and loads the register defaults.
`default_nettype none

module lidar_angular_scan_binner #(
  parameter int BINS = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire lasb_pkg::in_word_t           in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output lasb_pkg::out_word_t               out_word_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lasb_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int BinW  = $clog2(BINS);
  localparam int SlotW = BinW + 1;
  localparam int SlotN = 2 ** SlotW;

  lasb_pkg::cfg_t cfg;

  logic adv;

  logic               a_v_q;
  lasb_pkg::in_word_t a_q;
  logic [BinW-1:0]    a_ang_bin;

  logic              b_v_q;
  logic [1:0]        b_req_q;
  logic [15:0]       b_dist_q;
  logic [31:0]       b_ts_q;
  logic [BinW-1:0]   b_bin_q;
  logic              b_oor_q;
  logic              b_ok_q;
  logic              b_bank;
  logic [SlotW-1:0]  b_slot;

  logic              c_v_q;
  logic [1:0]        c_req_q;
  logic [15:0]       c_dist_q;
  logic [31:0]       c_ts_q;
  logic [SlotW-1:0]  c_slot_q;
  logic              c_oor_q;
  logic              c_ok_q;
  logic [15:0]       rdata_q;
  logic              fwd_q;
  logic [15:0]       fwd_data_q;

  logic [15:0]       c_old;
  logic [16:0]       c_sum;
  logic [15:0]       c_wdata;
  logic              c_we;
  logic              c_pulse_acc;
  logic              c_out_v;
  logic [31:0]       c_diff;
  lasb_pkg::out_word_t c_out;

  logic [15:0]       dist_mem [SlotN];
  logic [SlotN-1:0]  valid_q;
  logic [SlotN-1:0]  wr_q;
  logic              write_bank_q;
  logic [31:0]       last_q;

  logic                out_v_q;
  lasb_pkg::out_word_t out_q;

  lasb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lasb_angle_map #(
    .BINS (BINS)
  ) u_angle_map (
    .angle_pos_i    (a_q.angle_pos),
    .angle_offset_i (cfg.angle_offset),
    .bin_o          (a_ang_bin)
  );

  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // stage C: update, debounce and result
  always_comb begin
    c_old       = fwd_q ? fwd_data_q : rdata_q;
    c_sum       = {1'b0, c_old} + {1'b0, c_dist_q};
    c_wdata     = valid_q[c_slot_q] ? c_sum[16:1] : c_dist_q;
    c_diff      = c_ts_q - last_q;
    c_we        = 1'b0;
    c_pulse_acc = 1'b0;
    c_out_v     = 1'b0;
    c_out       = '0;
    unique case (c_req_q)
      lasb_pkg::REQ_MEAS: begin
        c_we = c_v_q && c_ok_q;
      end
      lasb_pkg::REQ_PULSE: begin
        c_pulse_acc             = c_v_q && (c_diff >= {12'd0, cfg.debounce_us});
        c_out_v                 = c_pulse_acc;
        c_out.result_kind       = lasb_pkg::KIND_SCAN_DONE;
        c_out.finished_bank     = write_bank_q;
      end
      lasb_pkg::REQ_READ: begin
        c_out_v             = c_v_q;
        c_out.result_kind   = lasb_pkg::KIND_BIN_READ;
        c_out.finished_bank = c_slot_q[SlotW-1];
        if (!c_oor_q) begin
          c_out.bin_distance = wr_q[c_slot_q] ? c_old : 16'd0;
          c_out.bin_valid    = valid_q[c_slot_q];
        end
      end
      default: ;
    endcase
  end

  // stage B: bank select with lookahead on a pulse taken in stage C
  always_comb begin
    b_bank = write_bank_q ^ c_pulse_acc;
    if (b_req_q == lasb_pkg::REQ_READ) begin
      b_bank = !b_bank;
    end
    b_slot = {b_bank, b_bin_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q        <= 1'b0;
      b_v_q        <= 1'b0;
      c_v_q        <= 1'b0;
      out_v_q      <= 1'b0;
      valid_q      <= '0;
      wr_q         <= '0;
      write_bank_q <= 1'b0;
      last_q       <= 32'd0;
    end else if (adv) begin
      a_v_q   <= in_valid_i;
      b_v_q   <= a_v_q;
      c_v_q   <= b_v_q;
      out_v_q <= c_out_v;
      if (c_we) begin
        valid_q[c_slot_q] <= 1'b1;
        wr_q[c_slot_q]    <= 1'b1;
      end
      if (c_pulse_acc) begin
        write_bank_q <= !write_bank_q;
        last_q       <= c_ts_q;
        for (int i = 0; i < BINS; i++) begin
          valid_q[{!write_bank_q, BinW'(i)}] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i) begin
        a_q <= in_word_i;
      end
      b_req_q  <= a_q.req_type;
      b_dist_q <= a_q.distance_cm;
      b_ts_q   <= a_q.timestamp_us;
      b_ok_q   <= a_q.distance_cm > cfg.min_distance;
      b_oor_q  <= 32'(a_q.bin_index) >= 32'(BINS);
      b_bin_q  <= (a_q.req_type == lasb_pkg::REQ_READ) ? BinW'(a_q.bin_index) : a_ang_bin;

      c_req_q    <= b_req_q;
      c_dist_q   <= b_dist_q;
      c_ts_q     <= b_ts_q;
      c_slot_q   <= b_slot;
      c_oor_q    <= b_oor_q;
      c_ok_q     <= b_ok_q;
      fwd_q      <= c_we && (c_slot_q == b_slot);
      fwd_data_q <= c_wdata;

      out_q <= c_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (c_we) begin
        dist_mem[c_slot_q] <= c_wdata;
      end
      rdata_q <= dist_mem[b_slot];
    end
  end

endmodule

`default_nettype wire

// ===== design/lasb_regs.sv =====
// APB configuration registers of the scan binner.
`default_nettype none

module lasb_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lasb_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output lasb_pkg::cfg_t                    cfg_o
);

  lasb_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance <= lasb_pkg::MinDistRst;
      cfg_q.debounce_us  <= lasb_pkg::DebounceRst;
      cfg_q.angle_offset <= lasb_pkg::AngleOfsRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        lasb_pkg::REG_MIN_DIST:  cfg_q.min_distance <= pwdata[15:0];
        lasb_pkg::REG_DEBOUNCE:  cfg_q.debounce_us  <= pwdata[19:0];
        lasb_pkg::REG_ANGLE_OFS: cfg_q.angle_offset <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lasb_pkg::REG_MIN_DIST:  prdata = {16'd0, cfg_q.min_distance};
      lasb_pkg::REG_DEBOUNCE:  prdata = {12'd0, cfg_q.debounce_us};
      lasb_pkg::REG_ANGLE_OFS: prdata = {17'd0, cfg_q.angle_offset};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lasb_angle_map.sv =====
// Turret angle to bin mapping: mirror, offset, wrap and scale by reciprocal multiply.
`default_nettype none

module lasb_angle_map #(
  parameter int BINS = 128
) (
  input  wire logic [14:0]              angle_pos_i,
  input  wire logic [14:0]              angle_offset_i,
  output logic      [$clog2(BINS)-1:0]  bin_o
);

  localparam int          BinW   = $clog2(BINS);
  localparam logic [14:0] Turn   = 15'(lasb_pkg::FullTurn);
  localparam logic [27:0] BinMul =
    28'((64'(BINS) * 64'd1073741824 + 64'(lasb_pkg::FullTurn) - 64'd1)
        / 64'(lasb_pkg::FullTurn));

  logic [14:0] pos_w;
  logic [14:0] ofs_w;
  logic [14:0] mir;
  logic [42:0] prod;

  always_comb begin
    pos_w = (angle_pos_i    >= Turn) ? angle_pos_i    - Turn : angle_pos_i;
    ofs_w = (angle_offset_i >= Turn) ? angle_offset_i - Turn : angle_offset_i;
    mir   = (ofs_w >= pos_w) ? ofs_w - pos_w : ofs_w + (Turn - pos_w);
    prod  = 43'(mir) * 43'(BinMul);
    bin_o = prod[30 +: BinW];
  end

endmodule

`default_nettype wire

// ===== design/lasb_checker.sv =====
// Port-level checks of the scan binner, bound to the top level.
`default_nettype none

module lasb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire lasb_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire lasb_pkg::out_word_t out_word_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result word");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.req_type == lasb_pkg::REQ_READ)
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("read word produced no result in time");

endmodule

bind lidar_angular_scan_binner lasb_checker u_checker (.*);

`default_nettype wire
